// ===== hw/rtl/mas_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes, constants and control structs for the motor arm and speed ramp block.
package mas_pkg;

   // motor states
   localparam logic [2:0] ST_DISARMED = 3'd0;
   localparam logic [2:0] ST_ARMING   = 3'd1;
   localparam logic [2:0] ST_ARMED    = 3'd2;
   localparam logic [2:0] ST_SPINNING = 3'd3;
   localparam logic [2:0] ST_ESTOP    = 3'd4;

   // command codes
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_ARM       = 3'd1;
   localparam logic [2:0] CMD_DISARM    = 3'd2;
   localparam logic [2:0] CMD_SET_SPEED = 3'd3;
   localparam logic [2:0] CMD_ESTOP     = 3'd4;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_ARM_DELAY     = 3'd0;
   localparam logic [2:0] REG_RAMP_INTERVAL = 3'd1;
   localparam logic [2:0] REG_RAMP_STEP     = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED     = 3'd3;
   localparam logic [2:0] REG_EXPO          = 3'd4;
   localparam logic [2:0] REG_PULSE_MIN     = 3'd5;
   localparam logic [2:0] REG_PULSE_MAX     = 3'd6;

   localparam int CSR_AW     = 5;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;

   // register reset values
   localparam logic [15:0] RST_ARM_DELAY     = 16'd1000;
   localparam logic [15:0] RST_RAMP_INTERVAL = 16'd50;
   localparam logic [6:0]  RST_RAMP_STEP     = 7'd5;
   localparam logic [6:0]  RST_MAX_SPEED     = 7'd100;
   localparam logic [6:0]  RST_EXPO          = 7'd0;
   localparam logic [15:0] RST_PULSE_MIN     = 16'd1000;
   localparam logic [15:0] RST_PULSE_MAX     = 16'd2000;

   localparam logic [6:0]  FULL_SCALE = 7'd100;
   localparam logic [13:0] LIN_SCALE  = 14'd10000;

   // floor(x / 15625) = (x * RECIP_15625) >> 35, exact for x < 2^21
   localparam logic [21:0] RECIP_15625 = 22'd2199024;
   // floor(x / 100) = (x * RECIP_100) >> 30, exact for x < 2^23
   localparam logic [23:0] RECIP_100   = 24'd10737419;

   typedef struct packed {
      logic load;
      logic eval;
      logic expo_a;
      logic expo_b;
      logic expo_c;
      logic expo_d;
      logic expo_wr;
      logic pulse_mul;
      logic pulse_div;
      logic pulse_wr;
      logic out_load;
   } mas_ctl_type;

   typedef struct packed {
      logic need_expo;
      logic need_pulse;
   } mas_sts_type;

endpackage

// ===== hw/rtl/motor_arm_and_speed_ramp.sv =====
`timescale 1ns / 1ps
// Top level of the motor arm and speed ramp controller.
//
//  channel  | direction | handshake                  | payload
//  req_     | in        | tvalid/tready              | tuser cmd, tdata now/safety/speed request
//  rsp_     | out       | tvalid/tready              | tdata accepted/state/speed/pulse/updated
//  csr_     | in/out    | psel/penable/pwrite/pready | 7 registers at byte address 4*index
//
// A word passes through the evaluate step and the done step, which loads its result
// into the output register; a tick that steps the ramp adds the multiply, reciprocal
// divide and write steps for the pulse width in between, and a set speed that is
// accepted adds the expo multiply chain, its divide and the target write in between.
// The next word is accepted as soon as the controller is idle, even while the
// last result still waits in the output register; a stalled result then holds
// the following word in its last step and blocks further input.
// Synchronous reset restores register defaults and disarms.
module motor_arm_and_speed_ramp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] now_ms, [32] safety_ok, [40:33] speed_request, [47:41] zero
   input  logic [mas_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] cmd
   input  logic [mas_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] accepted, [3:1] motor_state, [10:4] speed_now, [26:11] pulse_width,
   // [27] pulse_updated, [31:28] zero
   output logic [mas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mas_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   mas_pkg::mas_ctl_type ctl;
   mas_pkg::mas_sts_type sts;
   logic        csr_wr;
   logic        o_acc;
   logic [2:0]  o_state;
   logic [6:0]  o_speed;
   logic [15:0] o_pulse;
   logic        o_upd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   mas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   mas_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_cmd           (req_tuser[2:0]),
      .req_now_ms        (req_tdata[31:0]),
      .req_safety_ok     (req_tdata[32]),
      .req_speed_request (req_tdata[40:33]),
      .csr_wr            (csr_wr),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .rsp_accepted      (o_acc),
      .rsp_motor_state   (o_state),
      .rsp_speed_now     (o_speed),
      .rsp_pulse_width   (o_pulse),
      .rsp_pulse_updated (o_upd)
   );

   assign rsp_tdata = {4'd0, o_upd, o_pulse, o_speed, o_state, o_acc};

endmodule

// ===== hw/rtl/mas_dp.sv =====
`timescale 1ns / 1ps
// Datapath: registers, motor state, expo curve and pulse width arithmetic.
module mas_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  mas_pkg::mas_ctl_type      ctl,
   output mas_pkg::mas_sts_type      sts,
   input  logic [2:0]                req_cmd,
   input  logic [31:0]               req_now_ms,
   input  logic                      req_safety_ok,
   input  logic [7:0]                req_speed_request,
   input  logic                      csr_wr,
   input  logic [mas_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      rsp_accepted,
   output logic [2:0]                rsp_motor_state,
   output logic [6:0]                rsp_speed_now,
   output logic [15:0]               rsp_pulse_width,
   output logic                      rsp_pulse_updated
);

   // configuration registers
   logic [15:0] arm_delay_ff, arm_delay_in;
   logic [15:0] ramp_interval_ff, ramp_interval_in;
   logic [6:0]  ramp_step_ff, ramp_step_in;
   logic [6:0]  max_speed_ff, max_speed_in;
   logic [6:0]  expo_ff, expo_in;
   logic [15:0] pulse_min_ff, pulse_min_in;
   logic [15:0] pulse_max_ff, pulse_max_in;

   // motor state
   logic [2:0]  mode_ff, mode_in;
   logic [6:0]  cur_ff, cur_in;
   logic [6:0]  tgt_ff, tgt_in;
   logic [31:0] arm_start_ff, arm_start_in;
   logic [31:0] last_ramp_ff, last_ramp_in;
   logic [15:0] pulse_ff, pulse_in;

   // current word
   logic [2:0]  icmd_ff, icmd_in;
   logic [31:0] now_ff, now_in;
   logic        safe_ff, safe_in;
   logic [7:0]  ireq_ff, ireq_in;
   logic        acc_ff, acc_in;
   logic        upd_ff, upd_in;

   // expo pipeline
   logic [6:0]  s_ff, s_in;
   logic [6:0]  e_ff, e_in;
   logic [13:0] s2_ff, s2_in;
   logic [13:0] lin_a_ff, lin_a_in;
   logic [19:0] s3_ff, s3_in;
   logic [26:0] lin_ff, lin_in;
   logic [26:0] num_ff, num_in;
   logic [7:0]  quo_ff, quo_in;

   // pulse pipeline
   logic [22:0] pm_ff, pm_in;
   logic [15:0] pq_ff, pq_in;

   // result register
   logic        o_acc_ff, o_acc_in;
   logic [2:0]  o_state_ff, o_state_in;
   logic [6:0]  o_speed_ff, o_speed_in;
   logic [15:0] o_pulse_ff, o_pulse_in;
   logic        o_upd_ff, o_upd_in;

   // combinational helpers
   logic        live, run;
   logic [6:0]  step;
   logic [7:0]  up_sum, dn_lim;
   logic [6:0]  ramp_spd;
   logic [31:0] arm_elapsed, ramp_elapsed;
   logic        ramp_due;
   logic [6:0]  lim, e_cap, s_clamp;
   logic [20:0] s3_full;
   logic [26:0] cube;
   logic [42:0] quo_full;
   logic [15:0] range;
   logic [46:0] pq_full;

   always_comb begin
      csr_prdata = 32'd0;
      unique case (csr_paddr[4:2])
         mas_pkg::REG_ARM_DELAY:     csr_prdata = {16'd0, arm_delay_ff};
         mas_pkg::REG_RAMP_INTERVAL: csr_prdata = {16'd0, ramp_interval_ff};
         mas_pkg::REG_RAMP_STEP:     csr_prdata = {25'd0, ramp_step_ff};
         mas_pkg::REG_MAX_SPEED:     csr_prdata = {25'd0, max_speed_ff};
         mas_pkg::REG_EXPO:          csr_prdata = {25'd0, expo_ff};
         mas_pkg::REG_PULSE_MIN:     csr_prdata = {16'd0, pulse_min_ff};
         mas_pkg::REG_PULSE_MAX:     csr_prdata = {16'd0, pulse_max_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      arm_delay_in     = arm_delay_ff;
      ramp_interval_in = ramp_interval_ff;
      ramp_step_in     = ramp_step_ff;
      max_speed_in     = max_speed_ff;
      expo_in          = expo_ff;
      pulse_min_in     = pulse_min_ff;
      pulse_max_in     = pulse_max_ff;
      if (csr_wr) begin
         unique case (csr_paddr[4:2])
            mas_pkg::REG_ARM_DELAY:     arm_delay_in     = csr_pwdata[15:0];
            mas_pkg::REG_RAMP_INTERVAL: ramp_interval_in = csr_pwdata[15:0];
            mas_pkg::REG_RAMP_STEP:     ramp_step_in     = csr_pwdata[6:0];
            mas_pkg::REG_MAX_SPEED:     max_speed_in     = csr_pwdata[6:0];
            mas_pkg::REG_EXPO:          expo_in          = csr_pwdata[6:0];
            mas_pkg::REG_PULSE_MIN:     pulse_min_in     = csr_pwdata[15:0];
            mas_pkg::REG_PULSE_MAX:     pulse_max_in     = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // ramp decision for the latched word
   always_comb begin
      live = (mode_ff == mas_pkg::ST_ARMING) || (mode_ff == mas_pkg::ST_ARMED) ||
             (mode_ff == mas_pkg::ST_SPINNING);
      run  = (mode_ff == mas_pkg::ST_ARMED) || (mode_ff == mas_pkg::ST_SPINNING);
      if (ramp_step_ff == 7'd0)
         step = 7'd1;
      else if (ramp_step_ff > mas_pkg::FULL_SCALE)
         step = mas_pkg::FULL_SCALE;
      else
         step = ramp_step_ff;
      up_sum = {1'b0, cur_ff} + {1'b0, step};
      dn_lim = {1'b0, tgt_ff} + {1'b0, step};
      if (tgt_ff > cur_ff)
         ramp_spd = (up_sum < {1'b0, tgt_ff}) ? up_sum[6:0] : tgt_ff;
      else
         ramp_spd = ({1'b0, cur_ff} >= dn_lim) ? (cur_ff - step) : tgt_ff;
      arm_elapsed  = now_ff - arm_start_ff;
      ramp_elapsed = now_ff - last_ramp_ff;
      ramp_due     = (cur_ff != tgt_ff) && (ramp_elapsed > {16'd0, ramp_interval_ff});
      sts.need_expo  = (icmd_ff == mas_pkg::CMD_SET_SPEED) && run;
      sts.need_pulse = (icmd_ff == mas_pkg::CMD_TICK) && run && safe_ff && ramp_due;
   end

   // arithmetic stages
   always_comb begin
      lim      = (max_speed_ff > mas_pkg::FULL_SCALE) ? mas_pkg::FULL_SCALE : max_speed_ff;
      e_cap    = (expo_ff > mas_pkg::FULL_SCALE) ? mas_pkg::FULL_SCALE : expo_ff;
      s_clamp  = (ireq_ff > {1'b0, lim}) ? lim : ireq_ff[6:0];
      s3_full  = {7'd0, s2_ff} * {14'd0, s_ff};
      cube     = {7'd0, s3_ff} * {20'd0, e_ff};
      quo_full = {22'd0, num_ff[26:6]} * {21'd0, mas_pkg::RECIP_15625};
      range    = (pulse_max_ff >= pulse_min_ff) ? (pulse_max_ff - pulse_min_ff) : 16'd0;
      pq_full  = {24'd0, pm_ff} * {23'd0, mas_pkg::RECIP_100};
   end

   always_comb begin
      mode_in      = mode_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      arm_start_in = arm_start_ff;
      last_ramp_in = last_ramp_ff;
      pulse_in     = pulse_ff;
      icmd_in      = icmd_ff;
      now_in       = now_ff;
      safe_in      = safe_ff;
      ireq_in      = ireq_ff;
      acc_in       = acc_ff;
      upd_in       = upd_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      s2_in        = s2_ff;
      lin_a_in     = lin_a_ff;
      s3_in        = s3_ff;
      lin_in       = lin_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      pm_in        = pm_ff;
      pq_in        = pq_ff;
      o_acc_in     = o_acc_ff;
      o_state_in   = o_state_ff;
      o_speed_in   = o_speed_ff;
      o_pulse_in   = o_pulse_ff;
      o_upd_in     = o_upd_ff;

      if (ctl.load) begin
         icmd_in = req_cmd;
         now_in  = req_now_ms;
         safe_in = req_safety_ok;
         ireq_in = req_speed_request;
      end

      if (ctl.eval) begin
         acc_in = 1'b1;
         upd_in = 1'b0;
         case (icmd_ff)
            mas_pkg::CMD_TICK: begin
               if (live && !safe_ff) begin
                  mode_in  = mas_pkg::ST_ESTOP;
                  cur_in   = 7'd0;
                  tgt_in   = 7'd0;
                  pulse_in = pulse_min_ff;
                  upd_in   = 1'b1;
               end else if (mode_ff == mas_pkg::ST_ARMING) begin
                  pulse_in = pulse_min_ff;
                  if (arm_elapsed > {16'd0, arm_delay_ff})
                     mode_in = mas_pkg::ST_ARMED;
                  upd_in = 1'b1;
               end else if (run) begin
                  // pulse width follows in the pulse stages
                  if (ramp_due) begin
                     cur_in       = ramp_spd;
                     last_ramp_in = now_ff;
                     mode_in      = (ramp_spd != 7'd0) ? mas_pkg::ST_SPINNING
                                                       : mas_pkg::ST_ARMED;
                     upd_in       = 1'b1;
                  end
               end else begin
                  mode_in  = (mode_ff == mas_pkg::ST_ESTOP) ? mas_pkg::ST_ESTOP
                                                            : mas_pkg::ST_DISARMED;
                  cur_in   = 7'd0;
                  tgt_in   = 7'd0;
                  pulse_in = pulse_min_ff;
                  upd_in   = 1'b1;
               end
            end
            mas_pkg::CMD_ARM: begin
               if ((mode_ff == mas_pkg::ST_DISARMED) && safe_ff) begin
                  mode_in      = mas_pkg::ST_ARMING;
                  arm_start_in = now_ff;
               end else begin
                  acc_in = 1'b0;
               end
            end
            mas_pkg::CMD_DISARM: begin
               mode_in  = mas_pkg::ST_DISARMED;
               cur_in   = 7'd0;
               tgt_in   = 7'd0;
               pulse_in = pulse_min_ff;
               upd_in   = 1'b1;
            end
            mas_pkg::CMD_SET_SPEED: begin
               if (!run)
                  acc_in = 1'b0;
            end
            mas_pkg::CMD_ESTOP: begin
               mode_in  = mas_pkg::ST_ESTOP;
               cur_in   = 7'd0;
               tgt_in   = 7'd0;
               pulse_in = pulse_min_ff;
               upd_in   = 1'b1;
            end
            default: ;
         endcase
      end

      if (ctl.expo_a) begin
         s_in     = s_clamp;
         e_in     = e_cap;
         s2_in    = {7'd0, s_clamp} * {7'd0, s_clamp};
         lin_a_in = {7'd0, s_clamp} * {7'd0, mas_pkg::FULL_SCALE - e_cap};
      end
      if (ctl.expo_b) begin
         s3_in  = s3_full[19:0];
         lin_in = {13'd0, lin_a_ff} * {13'd0, mas_pkg::LIN_SCALE};
      end
      if (ctl.expo_c)
         num_in = lin_ff + cube;
      if (ctl.expo_d)
         quo_in = quo_full[42:35];
      if (ctl.expo_wr)
         tgt_in = (quo_ff > {1'b0, mas_pkg::FULL_SCALE}) ? mas_pkg::FULL_SCALE : quo_ff[6:0];

      if (ctl.pulse_mul)
         pm_in = {16'd0, cur_ff} * {7'd0, range};
      if (ctl.pulse_div)
         pq_in = pq_full[45:30];
      if (ctl.pulse_wr)
         pulse_in = pulse_min_ff + pq_ff;

      if (ctl.out_load) begin
         o_acc_in   = acc_ff;
         o_state_in = mode_ff;
         o_speed_in = cur_ff;
         o_pulse_in = pulse_ff;
         o_upd_in   = upd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_delay_ff     <= mas_pkg::RST_ARM_DELAY;
         ramp_interval_ff <= mas_pkg::RST_RAMP_INTERVAL;
         ramp_step_ff     <= mas_pkg::RST_RAMP_STEP;
         max_speed_ff     <= mas_pkg::RST_MAX_SPEED;
         expo_ff          <= mas_pkg::RST_EXPO;
         pulse_min_ff     <= mas_pkg::RST_PULSE_MIN;
         pulse_max_ff     <= mas_pkg::RST_PULSE_MAX;
         mode_ff          <= mas_pkg::ST_DISARMED;
         cur_ff           <= 7'd0;
         tgt_ff           <= 7'd0;
         arm_start_ff     <= 32'd0;
         last_ramp_ff     <= 32'd0;
         pulse_ff         <= mas_pkg::RST_PULSE_MIN;
      end else begin
         arm_delay_ff     <= arm_delay_in;
         ramp_interval_ff <= ramp_interval_in;
         ramp_step_ff     <= ramp_step_in;
         max_speed_ff     <= max_speed_in;
         expo_ff          <= expo_in;
         pulse_min_ff     <= pulse_min_in;
         pulse_max_ff     <= pulse_max_in;
         mode_ff          <= mode_in;
         cur_ff           <= cur_in;
         tgt_ff           <= tgt_in;
         arm_start_ff     <= arm_start_in;
         last_ramp_ff     <= last_ramp_in;
         pulse_ff         <= pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      icmd_ff    <= icmd_in;
      now_ff     <= now_in;
      safe_ff    <= safe_in;
      ireq_ff    <= ireq_in;
      acc_ff     <= acc_in;
      upd_ff     <= upd_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      s2_ff      <= s2_in;
      lin_a_ff   <= lin_a_in;
      s3_ff      <= s3_in;
      lin_ff     <= lin_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      pm_ff      <= pm_in;
      pq_ff      <= pq_in;
      o_acc_ff   <= o_acc_in;
      o_state_ff <= o_state_in;
      o_speed_ff <= o_speed_in;
      o_pulse_ff <= o_pulse_in;
      o_upd_ff   <= o_upd_in;
   end

   assign rsp_accepted      = o_acc_ff;
   assign rsp_motor_state   = o_state_ff;
   assign rsp_speed_now     = o_speed_ff;
   assign rsp_pulse_width   = o_pulse_ff;
   assign rsp_pulse_updated = o_upd_ff;

endmodule

// ===== hw/rtl/mas_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one word through evaluate, expo and pulse steps.
module mas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mas_pkg::mas_sts_type sts,
   output mas_pkg::mas_ctl_type ctl
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EVAL = 4'd1;
   localparam logic [3:0] S_EXA  = 4'd2;
   localparam logic [3:0] S_EXB  = 4'd3;
   localparam logic [3:0] S_EXC  = 4'd4;
   localparam logic [3:0] S_EXD  = 4'd5;
   localparam logic [3:0] S_EXW  = 4'd6;
   localparam logic [3:0] S_PMUL = 4'd7;
   localparam logic [3:0] S_PDIV = 4'd8;
   localparam logic [3:0] S_PWR  = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      ctl           = '0;
      ctl.load      = (state_ff == S_IDLE) && req_tvalid;
      ctl.eval      = (state_ff == S_EVAL);
      ctl.expo_a    = (state_ff == S_EXA);
      ctl.expo_b    = (state_ff == S_EXB);
      ctl.expo_c    = (state_ff == S_EXC);
      ctl.expo_d    = (state_ff == S_EXD);
      ctl.expo_wr   = (state_ff == S_EXW);
      ctl.pulse_mul = (state_ff == S_PMUL);
      ctl.pulse_div = (state_ff == S_PDIV);
      ctl.pulse_wr  = (state_ff == S_PWR);
      ctl.out_load  = (state_ff == S_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_EVAL;
         S_EVAL: begin
            if (sts.need_expo)
               state_in = S_EXA;
            else if (sts.need_pulse)
               state_in = S_PMUL;
            else
               state_in = S_DONE;
         end
         S_EXA:  state_in = S_EXB;
         S_EXB:  state_in = S_EXC;
         S_EXC:  state_in = S_EXD;
         S_EXD:  state_in = S_EXW;
         S_EXW:  state_in = S_DONE;
         S_PMUL: state_in = S_PDIV;
         S_PDIV: state_in = S_PWR;
         S_PWR:  state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result word until the sink takes it
   always_comb begin
      valid_in = valid_ff;
      if (ctl.out_load)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/mas_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the motor arm and speed ramp block, bound to the top level.
module mas_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mas_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic       acc;
   logic [2:0] mstate;
   logic [6:0] speed;
   logic       upd;

   assign acc    = rsp_tdata[0];
   assign mstate = rsp_tdata[3:1];
   assign speed  = rsp_tdata[10:4];
   assign upd    = rsp_tdata[27];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // only the spinning state carries a nonzero speed
   a_spin_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((mstate == mas_pkg::ST_SPINNING) == (speed != 7'd0)))
      else $error("speed and motor state disagree");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (speed <= mas_pkg::FULL_SCALE))
      else $error("speed above full scale");

   // a rejected arm or set speed never touches the pulse
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !acc |-> !upd)
      else $error("rejected command drove the pulse");

endmodule

bind motor_arm_and_speed_ramp mas_checker u_mas_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
